// ----- rtl/pnd_pkg.sv -----
// ----------------------------------------------------------------------------
// pnd_pkg: shared constants and a helper for the pink noise dice update core.
// Holds the fixed field widths and the trailing-zero encoder for the tick
// counter.
// ----------------------------------------------------------------------------
package pnd_pkg;

	// Fixed widths of the datapath.
	localparam int unsigned DATA_W = 32;
	localparam int unsigned DIE_W  = 28;
	localparam int unsigned CNT_W  = 16;
	localparam int unsigned TZ_W   = 4;
	localparam int unsigned NN_W   = 5;

	// Random words are divided by sixteen, which drops this many low bits.
	localparam int unsigned DIV_SHIFT = DATA_W - DIE_W;

	typedef logic [DATA_W-1:0] word_t;
	typedef logic [DIE_W-1:0]  die_t;
	typedef logic [CNT_W-1:0]  cnt_t;
	typedef logic [TZ_W-1:0]   tz_t;
	typedef logic [NN_W-1:0]   nn_t;

	// Trailing-zero count of a nonzero counter value. Scanning from the top
	// bit down leaves the lowest set bit's position in the result.
	function automatic tz_t tz_count(input cnt_t v);
		tz_t n;
		n = '0;
		for (int i = CNT_W - 1; i >= 0; i--) begin
			if (v[i]) begin
				n = tz_t'(i);
			end
		end
		return n;
	endfunction

endpackage

// ----- rtl/pnd_dice_bank.sv -----
// ----------------------------------------------------------------------------
// pnd_dice_bank: storage for the dice values.
// A synchronous memory with a registered read, per-entry valid bits
// so that unwritten dice read as zero, and forwarding of a write that lands
// on the entry being read in the same cycle.
// ----------------------------------------------------------------------------
module pnd_dice_bank #(
	parameter int unsigned DEPTH = 16,
	parameter int unsigned IDX_W = 4
) (
	input  logic             clk,
	input  logic             arst_n,
	input  logic             rd_en,
	input  logic [IDX_W-1:0] rd_idx,
	output pnd_pkg::die_t    rd_data,
	input  logic             wr_en,
	input  logic [IDX_W-1:0] wr_idx,
	input  pnd_pkg::die_t    wr_data
);
	import pnd_pkg::*;

	die_t             mem [DEPTH];
	logic [DEPTH-1:0] vld_q;
	die_t             ram_q;
	logic             rd_vld_q;
	logic             fwd_q;
	die_t             fwd_data_q;

	// Memory array: write port and registered read port.
	always_ff @(posedge clk) begin
		if (wr_en) begin
			mem[wr_idx] <= wr_data;
		end
		if (rd_en) begin
			ram_q <= mem[rd_idx];
		end
	end

	// Valid bits: every die reads as zero until it is first written.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_q <= '0;
		end else if (wr_en) begin
			vld_q[wr_idx] <= 1'b1;
		end
	end

	// Read-side status: valid flag and same-cycle write forwarding.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			rd_vld_q <= 1'b0;
			fwd_q    <= 1'b0;
		end else if (rd_en) begin
			rd_vld_q <= vld_q[rd_idx];
			fwd_q    <= wr_en && (wr_idx == rd_idx);
		end
	end

	// Forwarded data needs no reset.
	always_ff @(posedge clk) begin
		if (rd_en) begin
			fwd_data_q <= wr_data;
		end
	end

	// Read data selection; it holds until the next read.
	always_comb begin
		if (fwd_q) begin
			rd_data = fwd_data_q;
		end else if (rd_vld_q) begin
			rd_data = ram_q;
		end else begin
			rd_data = '0;
		end
	end

endmodule

// ----- rtl/pink_noise_dice_update_core.sv -----
// ----------------------------------------------------------------------------
// pink_noise_dice_update_core: Voss-McCartney pink noise sample generator.
// An accepted request passes stage one, then its result is registered out.
// Throughput: one request per cycle when out_stall is low, set by the single
// read-modify-write of the dice memory (read at acceptance, write at advance).
// Reset: dice, running sum, tick counter and nn_bits all clear to zero.
// Asynchronous active-low reset; the dice memory itself is cleared by valid bits.
// ----------------------------------------------------------------------------
module pink_noise_dice_update_core #(
	parameter int unsigned NUM_DICE = 16
) (
	input  logic                clk,
	input  logic                arst_n,
	input  logic                in_valid,
	output logic                in_stall,
	input  pnd_pkg::word_t      rand_die,
	input  pnd_pkg::word_t      rand_white,
	output logic                out_valid,
	input  logic                out_stall,
	output pnd_pkg::word_t      noise_word,
	input  logic                cfg_valid,
	output logic                cfg_ready,
	input  pnd_pkg::nn_t        cfg_data
);
	import pnd_pkg::*;

	localparam int unsigned IDX_W = (NUM_DICE > 1) ? $clog2(NUM_DICE) : 1;
	localparam int unsigned LAST  = NUM_DICE - 1;

	logic             in_acc;
	logic             adv;
	cnt_t             cnt_q;
	nn_t              nn_q;
	word_t            sum_q;
	tz_t              tz;
	logic [IDX_W-1:0] rd_idx;
	logic             upd;
	die_t             old_die;

	logic             valid_s1;
	logic             upd_s1;
	logic [IDX_W-1:0] idx_s1;
	die_t             fresh_s1;
	die_t             white_s1;

	word_t            new_sum;
	word_t            samp;
	word_t            mask;
	word_t            offset;
	word_t            result;
	logic             out_valid_q;
	word_t            noise_q;

	// Handshake control.
	assign adv       = valid_s1 && (!out_valid_q || !out_stall);
	assign in_stall  = valid_s1 && !adv;
	assign in_acc    = in_valid && !in_stall;
	assign cfg_ready = 1'b1;
	assign out_valid = out_valid_q;
	assign noise_word = noise_q;

	// Die selection from the tick counter, clamped to the last die.
	always_comb begin
		tz  = tz_count(cnt_q);
		upd = (cnt_q != '0);
		if (32'(tz) >= NUM_DICE) begin
			rd_idx = IDX_W'(LAST);
		end else begin
			rd_idx = IDX_W'(tz);
		end
	end

	// Configuration register and tick counter.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			nn_q  <= '0;
			cnt_q <= '0;
		end else begin
			if (cfg_valid) begin
				nn_q <= cfg_data;
			end
			if (in_acc) begin
				cnt_q <= cnt_q + cnt_t'(1);
			end
		end
	end

	// Dice storage.
	pnd_dice_bank #(
		.DEPTH (NUM_DICE),
		.IDX_W (IDX_W)
	) u_bank (
		.clk     (clk),
		.arst_n  (arst_n),
		.rd_en   (in_acc && upd),
		.rd_idx  (rd_idx),
		.rd_data (old_die),
		.wr_en   (adv && upd_s1),
		.wr_idx  (idx_s1),
		.wr_data (fresh_s1)
	);

	// Stage one control.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else begin
			valid_s1 <= in_acc || (valid_s1 && !adv);
		end
	end

	// Stage one payload.
	always_ff @(posedge clk) begin
		if (in_acc) begin
			upd_s1   <= upd;
			idx_s1   <= rd_idx;
			fresh_s1 <= rand_die[DATA_W-1:DIV_SHIFT];
			white_s1 <= rand_white[DATA_W-1:DIV_SHIFT];
		end
	end

	// Running sum update, white component, mask and offset.
	always_comb begin
		if (upd_s1) begin
			new_sum = sum_q - word_t'(old_die) + word_t'(fresh_s1);
		end else begin
			new_sum = sum_q;
		end
		samp   = new_sum + word_t'(white_s1);
		mask   = {DATA_W{1'b1}} << nn_q;
		offset = (~mask) >> 1;
		result = (samp & mask) + offset;
	end

	// Running sum and output valid.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			sum_q       <= '0;
			out_valid_q <= 1'b0;
		end else begin
			if (adv) begin
				sum_q <= new_sum;
			end
			out_valid_q <= adv || (out_valid_q && out_stall);
		end
	end

	// Output payload register.
	always_ff @(posedge clk) begin
		if (adv) begin
			noise_q <= result;
		end
	end

endmodule
